// ===== rtl/core/wave_grid_step_with_cell_bridge_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wave grid block
// Property forms used by wgs_back, the RTL file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef WAVE_GRID_STEP_WITH_CELL_BRIDGE_TOP_ASSERT_SVH
`define WAVE_GRID_STEP_WITH_CELL_BRIDGE_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define WGS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the following cycle.
`define WGS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wgs_pkg.sv =====
// ----------------------------------------------------------------------------
// wgs_pkg
// Types and constants shared by the wave grid front end, back end and top.
// ----------------------------------------------------------------------------
package wgs_pkg;

    localparam int COLUMN_W    = 7;
    localparam int ROW_W       = 6;
    localparam int AMP_W       = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Item actions.
    typedef enum logic [1:0] {
        ACT_STEP   = 2'd0,
        ACT_INJECT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_COUPLING   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIDGE_OPEN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRANCE_COLUMN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRANCE_ROW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_COLUMN     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_ROW        = 3'd6;

    // Pulse shape in Q8.24, by distance from the centre row.
    localparam logic signed [AMP_W-1:0] PULSE_D0 = 32'sd419430400;
    localparam logic signed [AMP_W-1:0] PULSE_D1 = 32'sd254397397;
    localparam logic signed [AMP_W-1:0] PULSE_D2 = 32'sd56763732;

    // Bridge coefficients in Q0.16.
    localparam logic [15:0] BRIDGE_GAIN  = 16'd62259;
    localparam logic [15:0] BRIDGE_DRAIN = 16'd6554;

    typedef struct packed {
        logic [15:0]         wave_coupling;
        logic [15:0]         damping;
        logic                bridge_open;
        logic [COLUMN_W-1:0] entrance_column;
        logic [ROW_W-1:0]    entrance_row;
        logic [COLUMN_W-1:0] exit_column;
        logic [ROW_W-1:0]    exit_row;
    } cfg_t;

    // Classified command; row is the adjusted centre for injects.
    typedef struct packed {
        action_t             action;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W:0]      row;
        logic                in_range;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE,
        ST_BR_RD,
        ST_BR_MUL1,
        ST_BR_WX,
        ST_BR_MUL2,
        ST_BR_WE,
        ST_INJ,
        ST_READ
    } back_state_t;

    // Saturate a wide signed value to the amplitude range.
    function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [39:0] x);
        logic signed [AMP_W-1:0] y;
        if (x > 40'sd2147483647)
            y = 32'sh7FFFFFFF;
        else if (x < -40'sd2147483648)
            y = 32'sh80000000;
        else
            y = x[AMP_W-1:0];
        return y;
    endfunction

endpackage

// ===== rtl/core/wgs_front.sv =====
// ----------------------------------------------------------------------------
// wgs_front
// Classifies accepted items and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module wgs_front #(
    parameter int GRID_COLUMNS = 110,
    parameter int GRID_ROWS    = 50
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push_en,
    input  logic [1:0]                      action,
    input  logic [wgs_pkg::COLUMN_W-1:0]    column,
    input  logic [wgs_pkg::ROW_W-1:0]       row,
    input  wgs_pkg::back_stat_t             stat,
    output wgs_pkg::cmd_req_t               req,
    output logic                            full
);
    import wgs_pkg::*;

    localparam logic [ROW_W:0] BOUNDARY = (ROW_W + 1)'(GRID_ROWS / 2);

    cmd_t       cls;
    logic       keep;
    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;

    // Classify the incoming item; no-ops and injects outside columns 1 to GRID_COLUMNS-1 are dropped.
    always_comb
    begin
        cls.action   = action_t'(action);
        cls.column   = column;
        cls.row      = {1'b0, row};
        cls.in_range = 1'b0;
        keep         = 1'b0;
        unique case (action_t'(action))
            ACT_STEP:
            begin
                keep = 1'b1;
            end
            ACT_INJECT:
            begin
                cls.in_range = (column != '0) && (column < GRID_COLUMNS);
                keep         = cls.in_range;
                if ({1'b0, row} == BOUNDARY)
                    cls.row = {1'b0, row} + 1'b1;
            end
            ACT_READ:
            begin
                cls.in_range = (column < GRID_COLUMNS) && (row < GRID_ROWS);
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = push_en && keep;

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (stat.pop)
                rptr_reg <= !rptr_reg;
            if (push && !stat.pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && stat.pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= cls;
    end

    assign req.valid = (count_reg != 2'd0);
    assign req.cmd   = entry_reg[rptr_reg];
    assign full      = (count_reg == 2'd2);

endmodule

// ===== rtl/core/wgs_back.sv =====
// ----------------------------------------------------------------------------
// wgs_back
// Executes commands against the three rotating grids: step sweep, bridge,
// pulse inject and cell read, plus the clearing pass after reset.
// ----------------------------------------------------------------------------
`include "wave_grid_step_with_cell_bridge_top_assert.svh"

module wgs_back #(
    parameter int GRID_COLUMNS = 110,
    parameter int GRID_ROWS    = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wgs_pkg::cfg_t                        cfg,
    input  wgs_pkg::cmd_req_t                    req,
    output wgs_pkg::back_stat_t                  stat,
    output logic                                 done,
    output logic signed [wgs_pkg::AMP_W-1:0]     amplitude
);
    import wgs_pkg::*;

    localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_COLUMNS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam logic [AW-1:0] ROWS_A = AW'(GRID_ROWS);

    back_state_t state_reg, state_next;

    logic [1:0]    phase_reg;
    logic [1:0]    cur_sel, prev_sel, next_sel;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] idx_reg;
    logic [2:0]    dist_reg;
    cmd_t          cmd_reg;
    logic          done_reg;
    logic signed [AMP_W-1:0] amp_reg;

    logic signed [AMP_W-1:0] c_reg, p_reg, up_reg, dn_reg, lf_reg;
    logic signed [35:0] lap_reg;
    logic signed [33:0] base_reg;
    logic signed [36:0] t_reg;
    logic signed [53:0] prod_reg;
    logic signed [AMP_W-1:0] ev_reg, xv_reg;
    logic signed [48:0] gprod_reg, dprod_reg;

    // Grid ports.
    logic [2:0]              mem_we;
    logic [AW-1:0]           waddr;
    logic signed [AMP_W-1:0] wdata;
    logic [AW-1:0]           raddr0 [3];
    logic [AW-1:0]           raddr1 [3];
    logic signed [AMP_W-1:0] rdata0 [3];
    logic signed [AMP_W-1:0] rdata1 [3];
    logic [AW-1:0]           rd_cur0, rd_cur1, rd_prev;
    logic                    w_cur, w_prev, w_next;
    logic signed [AMP_W-1:0] cur_d0, cur_d1, prev_d0;

    // Derived values.
    logic          boundary, sweep_last, bridge_ok, same_cell;
    logic [AW-1:0] e_idx, x_idx, read_idx, inj_idx;
    logic signed [7:0]  inj_y;
    logic          inj_ok;
    logic signed [AMP_W-1:0] pulse;
    logic signed [16:0] coup_s, damp_s, gain_s, drain_s;
    logic signed [52:0] acc_w, acc_r;
    logic signed [53:0] prod_r;
    logic signed [48:0] gprod_r, dprod_r;
    logic signed [AMP_W-1:0] new_x, new_e, cell_val;
    logic signed [35:0] lap_w;

    // Three grid memories, one write and two read ports each.
    for (genvar g = 0; g < 3; g++)
    begin : g_grid
        logic signed [AMP_W-1:0] grid_mem [CELLS];
        always_ff @(posedge clk)
        begin
            if (mem_we[g])
                grid_mem[waddr] <= wdata;
            rdata0[g] <= grid_mem[raddr0[g]];
            rdata1[g] <= grid_mem[raddr1[g]];
        end
    end

    // Grid roles follow the rotation phase.
    always_comb
    begin
        prev_sel = phase_reg;
        cur_sel  = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
        next_sel = (phase_reg == 2'd0) ? 2'd2 : phase_reg - 2'd1;
    end

    // Port routing by role.
    always_comb
    begin
        for (int g = 0; g < 3; g++)
        begin
            raddr0[g] = (cur_sel == 2'(g)) ? rd_cur0 : rd_prev;
            raddr1[g] = rd_cur1;
            mem_we[g] = (state_reg == ST_CLEAR)
                || (w_cur && cur_sel == 2'(g))
                || (w_prev && prev_sel == 2'(g))
                || (w_next && next_sel == 2'(g));
        end
        cur_d0  = rdata0[cur_sel];
        cur_d1  = rdata1[cur_sel];
        prev_d0 = rdata0[prev_sel];
    end

    // Addresses and conditions.
    always_comb
    begin
        boundary   = (row_reg == RW'(GRID_ROWS / 2));
        sweep_last = (row_reg == RW'(GRID_ROWS - 2)) && (col_reg == CW'(GRID_COLUMNS - 2));
        bridge_ok  = cfg.bridge_open
            && (cfg.entrance_column < GRID_COLUMNS) && (cfg.entrance_row < GRID_ROWS)
            && (cfg.exit_column < GRID_COLUMNS) && (cfg.exit_row < GRID_ROWS);
        e_idx      = AW'(cfg.entrance_column) * ROWS_A + AW'(cfg.entrance_row);
        x_idx      = AW'(cfg.exit_column) * ROWS_A + AW'(cfg.exit_row);
        same_cell  = (e_idx == x_idx);
        read_idx   = AW'(req.cmd.column) * ROWS_A + AW'(req.cmd.row);
        inj_y      = $signed({1'b0, cmd_reg.row}) + $signed({5'b0, dist_reg}) - 8'sd2;
        inj_ok     = (inj_y > 8'sd0) && (inj_y < GRID_ROWS);
        inj_idx    = AW'(cmd_reg.column) * ROWS_A + AW'($unsigned(inj_y));
        case (dist_reg)
            3'd2:          pulse = PULSE_D0;
            3'd1, 3'd3:    pulse = PULSE_D1;
            default:       pulse = PULSE_D2;
        endcase
    end

    // Arithmetic.
    always_comb
    begin
        coup_s   = $signed({1'b0, cfg.wave_coupling});
        damp_s   = $signed({1'b0, cfg.damping});
        gain_s   = $signed({1'b0, BRIDGE_GAIN});
        drain_s  = $signed({1'b0, BRIDGE_DRAIN});
        lap_w    = 36'(up_reg) + 36'(dn_reg) + 36'(lf_reg) + 36'(cur_d0)
            - (36'(c_reg) <<< 2);
        acc_w    = (53'(base_reg) <<< 16) + (coup_s * lap_reg);
        acc_r    = acc_w + 53'sd32768;
        prod_r   = prod_reg + 54'sd32768;
        cell_val = sat_amp(40'($signed(prod_r[53:16])));
        gprod_r  = gprod_reg + 49'sd32768;
        new_x    = sat_amp(40'(xv_reg) + 40'($signed(gprod_r[48:16])));
        dprod_r  = dprod_reg + 49'sd32768;
        new_e    = sat_amp(40'($signed(dprod_r[48:16])));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == AW'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.cmd.action)
                        ACT_STEP:   state_next = ST_CELL;
                        ACT_INJECT: state_next = ST_INJ;
                        ACT_READ:   state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CELL:
            begin
                if (!boundary)
                    state_next = ST_RD1;
                else if (sweep_last)
                    state_next = ST_BR_RD;
            end
            ST_RD1:     state_next = ST_RD2;
            ST_RD2:     state_next = ST_RD3;
            ST_RD3:     state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_WRITE;
            ST_WRITE:   state_next = sweep_last ? ST_BR_RD : ST_CELL;
            ST_BR_RD:   state_next = bridge_ok ? ST_BR_MUL1 : ST_IDLE;
            ST_BR_MUL1: state_next = ST_BR_WX;
            ST_BR_WX:   state_next = ST_BR_MUL2;
            ST_BR_MUL2: state_next = ST_BR_WE;
            ST_BR_WE:   state_next = ST_IDLE;
            ST_INJ:     if (dist_reg == 3'd4) state_next = ST_IDLE;
            ST_READ:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory controls and status by state.
    always_comb
    begin
        rd_cur0 = '0;
        rd_cur1 = '0;
        rd_prev = '0;
        w_cur   = 1'b0;
        w_prev  = 1'b0;
        w_next  = 1'b0;
        waddr   = idx_reg;
        wdata   = '0;
        stat.pop      = 1'b0;
        stat.clearing = (state_reg == ST_CLEAR);
        unique case (state_reg)
            ST_CLEAR:   waddr = clr_reg;
            ST_IDLE:
            begin
                stat.pop = req.valid;
                if (req.cmd.in_range)
                    rd_cur0 = read_idx;
            end
            ST_CELL:
            begin
                if (boundary)
                    w_cur = 1'b1;
                else
                begin
                    rd_cur0 = idx_reg;
                    rd_cur1 = idx_reg - 1'b1;
                    rd_prev = idx_reg;
                end
            end
            ST_RD1:
            begin
                rd_cur0 = idx_reg + 1'b1;
                rd_cur1 = idx_reg - ROWS_A;
            end
            ST_RD2:     rd_cur0 = idx_reg + ROWS_A;
            ST_WRITE:
            begin
                w_next = 1'b1;
                wdata  = cell_val;
            end
            ST_BR_RD:
            begin
                rd_cur0 = e_idx;
                rd_cur1 = x_idx;
            end
            ST_BR_WX:
            begin
                w_cur = 1'b1;
                waddr = x_idx;
                wdata = new_x;
            end
            ST_BR_WE:
            begin
                w_cur = 1'b1;
                waddr = e_idx;
                wdata = new_e;
            end
            ST_INJ:
            begin
                w_cur  = inj_ok;
                w_prev = inj_ok;
                waddr  = inj_idx;
                wdata  = pulse;
            end
            default:
            begin
                waddr = idx_reg;
            end
        endcase
    end

    // Control registers: state, phase, sweep counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            phase_reg <= 2'd0;
            clr_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            idx_reg   <= '0;
            dist_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_READ);
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE)
            begin
                col_reg  <= CW'(1);
                row_reg  <= RW'(1);
                idx_reg  <= ROWS_A + 1'b1;
                dist_reg <= '0;
            end
            if (state_reg == ST_INJ)
                dist_reg <= dist_reg + 3'd1;
            // Advance the sweep, skipping the edge rows between columns.
            if ((state_reg == ST_CELL && boundary) || state_reg == ST_WRITE)
            begin
                if (row_reg == RW'(GRID_ROWS - 2))
                begin
                    row_reg <= RW'(1);
                    col_reg <= col_reg + 1'b1;
                    idx_reg <= idx_reg + AW'(3);
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            // Rotate the grids at the end of a step.
            if ((state_reg == ST_BR_RD && !bridge_ok) || state_reg == ST_BR_WE)
                phase_reg <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:    cmd_reg <= req.cmd;
            ST_RD1:
            begin
                c_reg  <= cur_d0;
                up_reg <= cur_d1;
                p_reg  <= prev_d0;
            end
            ST_RD2:
            begin
                dn_reg <= cur_d0;
                lf_reg <= cur_d1;
            end
            ST_RD3:
            begin
                lap_reg  <= lap_w;
                base_reg <= (34'(c_reg) <<< 1) - 34'(p_reg);
            end
            ST_MUL1:    t_reg <= $signed(acc_r[52:16]);
            ST_MUL2:    prod_reg <= t_reg * damp_s;
            ST_BR_MUL1:
            begin
                ev_reg    <= cur_d0;
                xv_reg    <= cur_d1;
                gprod_reg <= cur_d0 * gain_s;
            end
            ST_BR_WX:   if (same_cell) ev_reg <= new_x;
            ST_BR_MUL2: dprod_reg <= ev_reg * drain_s;
            ST_READ:    amp_reg <= cmd_reg.in_range ? cur_d0 : '0;
            default:    amp_reg <= amp_reg;
        endcase
    end

    assign done      = done_reg;
    assign amplitude = amp_reg;

    `WGS_ASSERT_NEXT(a_read_gives_result, clk, rst_n, state_reg == ST_READ, done_reg,
        "read did not produce a result")
    `WGS_ASSERT_IMPL(a_result_from_read, clk, rst_n, done_reg,
        $past(state_reg) == ST_READ, "result without a read")
    `WGS_ASSERT_IMPL(a_sweep_index, clk, rst_n, state_reg == ST_CELL,
        idx_reg == AW'(col_reg) * ROWS_A + AW'(row_reg), "sweep address out of step")
    `WGS_ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, phase_reg != 2'd3,
        "rotation phase out of range")

endmodule

// ===== rtl/core/wave_grid_step_with_cell_bridge_top.sv =====
// ----------------------------------------------------------------------------
// wave_grid_step_with_cell_bridge_top
// Leapfrog wave grid with a cell bridge: configuration registers, command
// front end with a two-entry queue, and the grid execution back end.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a read returns its
// amplitude on the cycle done is high, and the receiver cannot stall it.
// The back end computes one cell at a time through two read ports per
// grid: an interior cell off the boundary row passes through the cell,
// read, multiply and write states, a boundary-row cell only through the
// cell state, and each step ends with the bridge states. An inject steps
// through the pulse rows in the inject state. After reset a clearing
// pass zeroes the grids while busy is high.
// Up to two items queue while a step runs; write configuration only when
// all queued work has finished.
module wave_grid_step_with_cell_bridge_top #(
    parameter int GRID_COLUMNS = 110,
    parameter int GRID_ROWS    = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           action,
    input  logic [wgs_pkg::COLUMN_W-1:0]         column,
    input  logic [wgs_pkg::ROW_W-1:0]            row,
    input  logic                                 wr_en,
    input  logic [wgs_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [wgs_pkg::CFG_DATA_W-1:0]       wr_data,
    output logic                                 done,
    output logic signed [wgs_pkg::AMP_W-1:0]     amplitude
);
    import wgs_pkg::*;

    cfg_t       cfg_reg;
    cmd_req_t   req;
    back_stat_t stat;
    logic       full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_coupling   <= 16'd15073;
            cfg_reg.damping         <= 16'd64553;
            cfg_reg.bridge_open     <= 1'b0;
            cfg_reg.entrance_column <= 7'd75;
            cfg_reg.entrance_row    <= 6'd12;
            cfg_reg.exit_column     <= 7'd25;
            cfg_reg.exit_row        <= 6'd37;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_WAVE_COUPLING:   cfg_reg.wave_coupling   <= wr_data;
                CFG_DAMPING:         cfg_reg.damping         <= wr_data;
                CFG_BRIDGE_OPEN:     cfg_reg.bridge_open     <= wr_data[0];
                CFG_ENTRANCE_COLUMN: cfg_reg.entrance_column <= wr_data[COLUMN_W-1:0];
                CFG_ENTRANCE_ROW:    cfg_reg.entrance_row    <= wr_data[ROW_W-1:0];
                CFG_EXIT_COLUMN:     cfg_reg.exit_column     <= wr_data[COLUMN_W-1:0];
                CFG_EXIT_ROW:        cfg_reg.exit_row        <= wr_data[ROW_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Accept while the queue has room and the grids are cleared.
    assign busy = full || stat.clearing;

    wgs_front #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (start && !busy),
        .action  (action),
        .column  (column),
        .row     (row),
        .stat    (stat),
        .req     (req),
        .full    (full)
    );

    wgs_back #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .stat      (stat),
        .done      (done),
        .amplitude (amplitude)
    );

endmodule
